@@ src/lqd_pkg.sv @@
// Shared types and constants of the least-loaded queue dispatcher.
package lqd_pkg;

    // Fixed field widths of the item and result channels.
    localparam int MODE_W   = 2;
    localparam int QNUM_W   = 4;
    localparam int TAG_IN_W = 16;
    localparam int PAGES_W  = 16;
    localparam int MIN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int DONE_W   = 8;
    localparam int CFG_W    = 4;

    // Input modes as they arrive on the item channel.
    localparam logic [MODE_W-1:0] MODE_NAMED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEAST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    // Operation classes handed from the front end to the engine.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NAMED   = 2'd0;
    localparam logic [OP_W-1:0] OP_LEAST   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_Q   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP_TAG = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // One classified command waiting for the engine.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [QNUM_W-1:0]   queue_number;
        logic [TAG_IN_W-1:0] job_tag;
        logic [PAGES_W-1:0]  job_pages;
        logic [MIN_W-1:0]    minutes;
    } cmd_t;

endpackage

@@ src/lqd_if.sv @@
// Item and result channel interfaces of the dispatcher.
interface lqd_req_if;
    logic                         valid;
    logic                         ready;
    logic [lqd_pkg::MODE_W-1:0]   mode;
    logic [lqd_pkg::QNUM_W-1:0]   queue_number;
    logic [lqd_pkg::TAG_IN_W-1:0] job_tag;
    logic [lqd_pkg::PAGES_W-1:0]  job_pages;
    logic [lqd_pkg::MIN_W-1:0]    minutes;

    modport source (output valid, mode, queue_number, job_tag, job_pages, minutes,
                    input ready);
    modport sink (input valid, mode, queue_number, job_tag, job_pages, minutes,
                  output ready);
endinterface

interface lqd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lqd_pkg::STATUS_W-1:0] status;
    logic [lqd_pkg::QNUM_W-1:0]   queue_used;
    logic [lqd_pkg::DONE_W-1:0]   jobs_completed;
    logic [lqd_pkg::QNUM_W-1:0]   least_loaded;

    modport source (output valid, status, queue_used, jobs_completed, least_loaded,
                    input ready);
    modport sink (input valid, status, queue_used, jobs_completed, least_loaded,
                  output ready);
endinterface

@@ src/least_loaded_multi_queue_dispatcher.sv @@
// Top level of the least-loaded multi-queue job dispatcher.
// Items enter a two-entry command queue and are carried out one at a time by an
// engine that owns a single-port job store (one read or one write per cycle).
// Every item ends with a scan of the active queues' loads, one queue per cycle.
// An insert walks every queued job of the active queues for a duplicate tag, then
// appends the job; a least-loaded insert adds one more scan first. An advance
// spends the budget on the head jobs of each active queue in turn. Results
// wait in an output register while the next items are queued.
module least_loaded_multi_queue_dispatcher #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lqd_req_if.sink     req,
    lqd_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lqd_pkg::CFG_W-1:0] queues_in_use_reg, queues_in_use_next;
    logic                      cmd_valid;
    logic                      cmd_ready;
    lqd_pkg::cmd_t             cmd;

    // Configuration register: active queue count.
    assign pready = 1'b1;
    assign prdata = {{(32 - lqd_pkg::CFG_W){1'b0}}, queues_in_use_reg};

    always_comb
    begin
        queues_in_use_next = queues_in_use_reg;
        if (psel && penable && pwrite && !paddr[2])
        begin
            queues_in_use_next = pwdata[lqd_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queues_in_use_reg <= lqd_pkg::CFG_W'(1);
        end
        else
        begin
            queues_in_use_reg <= queues_in_use_next;
        end
    end

    lqd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    lqd_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .cfg_queues (queues_in_use_reg),
        .rsp        (rsp)
    );

endmodule

@@ src/lqd_ram.sv @@
// Generic single-port RAM with registered read data.
module lqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/lqd_front.sv @@
// Front end: accepts items, classifies them and queues them for the engine.
module lqd_front (
    input  logic          clk,
    input  logic          rst_n,
    lqd_req_if.sink       req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output lqd_pkg::cmd_t cmd
);

    lqd_pkg::cmd_t slot_reg [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    lqd_pkg::cmd_t in_cmd;
    logic          push, pop;

    // Classify the incoming mode into an engine operation.
    always_comb
    begin
        in_cmd.queue_number = req.queue_number;
        in_cmd.job_tag      = req.job_tag;
        in_cmd.job_pages    = req.job_pages;
        in_cmd.minutes      = req.minutes;
        case (req.mode)
            lqd_pkg::MODE_NAMED:   in_cmd.op = lqd_pkg::OP_NAMED;
            lqd_pkg::MODE_LEAST:   in_cmd.op = lqd_pkg::OP_LEAST;
            lqd_pkg::MODE_ADVANCE: in_cmd.op = lqd_pkg::OP_ADVANCE;
            default:               in_cmd.op = lqd_pkg::OP_NOP;
        endcase
    end

    // Two-entry command queue between the front end and the engine.
    assign req.ready = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rp_reg];
    assign push      = req.valid && req.ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Command payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

@@ src/lqd_back.sv @@
// Engine: runs queued commands against the job store and produces results.
module lqd_back #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  lqd_pkg::cmd_t               cmd,
    input  logic [lqd_pkg::CFG_W-1:0]   cfg_queues,
    lqd_rsp_if.source                   rsp
);

    localparam int QI_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int NQC_W = $clog2(NUM_QUEUES + 1);
    localparam int SW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = lqd_pkg::PAGES_W + CW;
    localparam int TW    = (TAG_BITS < lqd_pkg::TAG_IN_W) ? TAG_BITS : lqd_pkg::TAG_IN_W;
    localparam int PW    = lqd_pkg::PAGES_W;
    localparam int AW    = QI_W + SW;
    localparam int DW    = TW + PW;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIND     = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_PUT      = 3'd4;
    localparam logic [2:0] S_DRN_RD   = 3'd5;
    localparam logic [2:0] S_DRN_UPD  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [NQC_W-1:0] cur_reg, cur_next;
    logic [CW-1:0]    si_reg, si_next;
    logic [PW-1:0]    budget_reg, budget_next;
    logic [lqd_pkg::DONE_W-1:0] done_reg, done_next;
    logic [QI_W-1:0]  best_reg, best_next;
    logic [LW-1:0]    best_load_reg, best_load_next;
    logic             final_reg, final_next;
    logic [QI_W-1:0]  target_reg, target_next;
    lqd_pkg::cmd_t    cmd_reg, cmd_next;
    logic [lqd_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [lqd_pkg::QNUM_W-1:0]   used_reg, used_next;

    logic [SW-1:0]    head_reg [NUM_QUEUES];
    logic [SW-1:0]    head_next [NUM_QUEUES];
    logic [CW-1:0]    count_reg [NUM_QUEUES];
    logic [CW-1:0]    count_next [NUM_QUEUES];
    logic [LW-1:0]    load_reg [NUM_QUEUES];
    logic [LW-1:0]    load_next [NUM_QUEUES];

    logic             out_valid_reg, out_valid_next;
    logic [lqd_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [lqd_pkg::QNUM_W-1:0]   out_used_reg, out_used_next;
    logic [lqd_pkg::DONE_W-1:0]   out_done_reg, out_done_next;
    logic [lqd_pkg::QNUM_W-1:0]   out_least_reg, out_least_next;

    logic             ram_re, ram_we;
    logic [AW-1:0]    ram_addr;
    logic [DW-1:0]    ram_wdata, ram_rdata;

    logic [NQC_W-1:0] act_n;
    logic [QI_W-1:0]  cq;
    logic [TW-1:0]    tag_m;
    logic [TW-1:0]    rd_tag;
    logic [PW-1:0]    rd_pages;

    // Wraps a slot offset around the circular buffer of one queue.
    function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] h, input logic [SW-1:0] o);
        logic [SW:0] s;
        s = {1'b0, h} + {1'b0, o};
        if (s >= (SW+1)'(QUEUE_DEPTH))
        begin
            s = s - (SW+1)'(QUEUE_DEPTH);
        end
        return s[SW-1:0];
    endfunction

    // Job store: one word per slot holds the tag and the pages left.
    lqd_ram #(
        .WIDTH (DW),
        .DEPTH (1 << AW)
    ) u_store (
        .clk   (clk),
        .re    (ram_re),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Active queue count saturated into its legal range.
    always_comb
    begin
        if (cfg_queues == '0)
        begin
            act_n = NQC_W'(1);
        end
        else if (int'(cfg_queues) > NUM_QUEUES)
        begin
            act_n = NQC_W'(NUM_QUEUES);
        end
        else
        begin
            act_n = NQC_W'(cfg_queues);
        end
    end

    assign cq       = cur_reg[QI_W-1:0];
    assign tag_m    = cmd_reg.job_tag[TW-1:0];
    assign rd_tag   = ram_rdata[DW-1:PW];
    assign rd_pages = ram_rdata[PW-1:0];

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        si_next        = si_reg;
        budget_next    = budget_reg;
        done_next      = done_reg;
        best_next      = best_reg;
        best_load_next = best_load_reg;
        final_next     = final_reg;
        target_next    = target_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        load_next      = load_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_used_next   = out_used_reg;
        out_done_next   = out_done_reg;
        out_least_next  = out_least_reg;
        cmd_ready      = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = '0;
        ram_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_ready   = 1'b1;
                    cmd_next    = cmd;
                    status_next = lqd_pkg::ST_OK;
                    used_next   = '0;
                    done_next   = '0;
                    cur_next    = '0;
                    si_next     = '0;
                    budget_next = cmd.minutes;
                    final_next  = 1'b1;
                    case (cmd.op)
                        lqd_pkg::OP_NAMED:
                        begin
                            if (cmd.queue_number == '0 ||
                                int'(cmd.queue_number) > int'(act_n))
                            begin
                                status_next = lqd_pkg::ST_BAD_Q;
                                state_next  = S_FIND;
                            end
                            else
                            begin
                                target_next = QI_W'(cmd.queue_number - 1'b1);
                                state_next  = S_SRCH_RD;
                            end
                        end
                        lqd_pkg::OP_LEAST:
                        begin
                            final_next = 1'b0;
                            state_next = S_FIND;
                        end
                        lqd_pkg::OP_ADVANCE:
                        begin
                            state_next = S_DRN_RD;
                        end
                        default:
                        begin
                            state_next = S_FIND;
                        end
                    endcase
                end
            end

            // Scan the active queues for the lowest load, lowest number first.
            S_FIND:
            begin
                if (cur_reg >= act_n)
                begin
                    if (final_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = status_reg;
                        out_used_next   = used_reg;
                        out_done_next   = done_reg;
                        out_least_next  = lqd_pkg::QNUM_W'(best_reg) + 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        // The next scan is the closing one for this item.
                        target_next = best_reg;
                        final_next  = 1'b1;
                        cur_next    = '0;
                        si_next     = '0;
                        state_next  = S_SRCH_RD;
                    end
                end
                else
                begin
                    if (cur_reg == '0 || load_reg[cq] < best_load_reg)
                    begin
                        best_next      = cq;
                        best_load_next = load_reg[cq];
                    end
                    cur_next = cur_reg + 1'b1;
                end
            end

            // Walk every queued job of the active queues looking for the tag.
            S_SRCH_RD:
            begin
                if (cur_reg >= act_n)
                begin
                    cur_next   = NQC_W'(target_reg);
                    state_next = S_PUT;
                end
                else if (si_reg >= count_reg[cq])
                begin
                    cur_next = cur_reg + 1'b1;
                    si_next  = '0;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_addr   = {cq, slot_add(head_reg[cq], si_reg[SW-1:0])};
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (rd_tag == tag_m)
                begin
                    status_next = lqd_pkg::ST_DUP_TAG;
                    cur_next    = '0;
                    state_next  = S_FIND;
                end
                else
                begin
                    si_next    = si_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end

            // Append the job at the tail of the target queue, or report the queue full.
            S_PUT:
            begin
                if (count_reg[cq] == CW'(QUEUE_DEPTH))
                begin
                    status_next = lqd_pkg::ST_FULL;
                end
                else
                begin
                    ram_we        = 1'b1;
                    ram_addr      = {cq, slot_add(head_reg[cq], count_reg[cq][SW-1:0])};
                    ram_wdata     = {tag_m, cmd_reg.job_pages};
                    count_next[cq] = count_reg[cq] + 1'b1;
                    load_next[cq]  = load_reg[cq] + LW'(cmd_reg.job_pages);
                    used_next      = lqd_pkg::QNUM_W'(target_reg) + 1'b1;
                end
                cur_next   = '0;
                state_next = S_FIND;
            end

            // Read the head job of the current queue.
            S_DRN_RD:
            begin
                if (cur_reg >= act_n)
                begin
                    cur_next   = '0;
                    state_next = S_FIND;
                end
                else if (count_reg[cq] == '0)
                begin
                    cur_next    = cur_reg + 1'b1;
                    budget_next = cmd_reg.minutes;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_addr   = {cq, head_reg[cq]};
                    state_next = S_DRN_UPD;
                end
            end

            // Spend the budget on the head job: finish it or leave it partial.
            S_DRN_UPD:
            begin
                if (rd_pages > budget_reg)
                begin
                    ram_we        = 1'b1;
                    ram_addr      = {cq, head_reg[cq]};
                    ram_wdata     = {rd_tag, rd_pages - budget_reg};
                    load_next[cq] = load_reg[cq] - LW'(budget_reg);
                    cur_next      = cur_reg + 1'b1;
                    budget_next   = cmd_reg.minutes;
                end
                else
                begin
                    budget_next    = budget_reg - rd_pages;
                    load_next[cq]  = load_reg[cq] - LW'(rd_pages);
                    head_next[cq]  = slot_add(head_reg[cq], SW'(1));
                    count_next[cq] = count_reg[cq] - 1'b1;
                    if (done_reg != '1)
                    begin
                        done_next = done_reg + 1'b1;
                    end
                end
                state_next = S_DRN_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            si_reg        <= '0;
            budget_reg    <= '0;
            done_reg      <= '0;
            best_reg      <= '0;
            best_load_reg <= '0;
            final_reg     <= 1'b0;
            target_reg    <= '0;
            status_reg    <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                load_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            si_reg        <= si_next;
            budget_reg    <= budget_next;
            done_reg      <= done_next;
            best_reg      <= best_next;
            best_load_reg <= best_load_next;
            final_reg     <= final_next;
            target_reg    <= target_next;
            status_reg    <= status_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            load_reg      <= load_next;
        end
    end

    // Payload registers of the command and the result.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        out_status_reg <= out_status_next;
        out_used_reg   <= out_used_next;
        out_done_reg   <= out_done_next;
        out_least_reg  <= out_least_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.queue_used     = out_used_reg;
    assign rsp.jobs_completed = out_done_reg;
    assign rsp.least_loaded   = out_least_reg;

endmodule

@@ test/lqd_scoreboard.sv @@
// Checker that predicts dispatcher results from the channels and compares them.
module lqd_scoreboard
    import lqd_pkg::*;
#(
    parameter logic [2:0] CFG_ADDR = 3'd0
) (
    input  logic  clk,
    input  logic  rst_n,
    lqd_req_if    req,
    lqd_rsp_if    rsp,
    input  logic  psel,
    input  logic  penable,
    input  logic  pwrite,
    input  logic  pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int    errors,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ    = 8;
    localparam int DEPTH = 16;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [QNUM_W-1:0]   queue_used;
        logic [DONE_W-1:0]   jobs_completed;
        logic [QNUM_W-1:0]   least_loaded;
    } outcome_t;

    // Mirror of the job queues, the loads and the active-queue register.
    logic [TAG_IN_W-1:0] job_tags[NQ][$];
    int unsigned         job_pages_left[NQ][$];
    int unsigned         queue_load[NQ];
    logic [CFG_W-1:0]    active_reg;
    outcome_t            expected_results[$];

    function automatic int active_count();
        if (active_reg < 1) return 1;
        if (active_reg > NQ) return NQ;
        return active_reg;
    endfunction

    function automatic int lightest_queue();
        int best;
        best = 0;
        for (int q = 1; q < active_count(); q++)
            if (queue_load[q] < queue_load[best]) best = q;
        return best + 1;
    endfunction

    // Applies one insert and returns its status; used is the 1-based queue.
    function automatic logic [STATUS_W-1:0] place_job(int qnum, logic [TAG_IN_W-1:0] tag,
                                                       int unsigned pages, output int used);
        used = 0;
        if (qnum < 1 || qnum > active_count()) return ST_BAD_Q;
        for (int q = 0; q < active_count(); q++)
            foreach (job_tags[q][i])
                if (job_tags[q][i] == tag) return ST_DUP_TAG;
        if (job_tags[qnum-1].size() >= DEPTH) return ST_FULL;
        job_tags[qnum-1].push_back(tag);
        job_pages_left[qnum-1].push_back(pages);
        queue_load[qnum-1] += pages;
        used = qnum;
        return ST_OK;
    endfunction

    // Each active queue spends the budget on its head jobs; returns finished jobs.
    function automatic int spend_minutes(int unsigned budget);
        int finished;
        int unsigned left;
        finished = 0;
        for (int q = 0; q < active_count(); q++)
        begin
            left = budget;
            while (job_tags[q].size() > 0)
            begin
                if (job_pages_left[q][0] > left)
                begin
                    job_pages_left[q][0] -= left;
                    queue_load[q] -= left;
                    break;
                end
                left -= job_pages_left[q][0];
                queue_load[q] -= job_pages_left[q][0];
                void'(job_tags[q].pop_front());
                void'(job_pages_left[q].pop_front());
                finished++;
            end
        end
        return finished;
    endfunction

    function automatic outcome_t predict_dispatch(logic [MODE_W-1:0] mode, int qnum,
                                                  logic [TAG_IN_W-1:0] tag,
                                                  int unsigned pages, int unsigned mins);
        outcome_t r;
        int used;
        int done;
        r = '0;
        used = 0;
        if (mode == MODE_NAMED)
            r.status = place_job(qnum, tag, pages, used);
        else if (mode == MODE_LEAST)
            r.status = place_job(lightest_queue(), tag, pages, used);
        else if (mode == MODE_ADVANCE)
        begin
            done = spend_minutes(mins);
            r.jobs_completed = (done > 255) ? 8'd255 : done[7:0];
        end
        r.queue_used   = used[QNUM_W-1:0];
        r.least_loaded = lightest_queue();
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int q = 0; q < NQ; q++)
            begin
                job_tags[q].delete();
                job_pages_left[q].delete();
                queue_load[q] = 0;
            end
            active_reg = 1;
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            // Compare a delivered result with the oldest expectation.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d used=%0d done=%0d least=%0d",
                             $realtime, rsp.status, rsp.queue_used, rsp.jobs_completed,
                             rsp.least_loaded);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.queue_used !== want.queue_used)
                    begin
                        $display("%0t: queue_used expected %0d actual %0d", $realtime,
                                 want.queue_used, rsp.queue_used);
                        errors++;
                    end
                    if (rsp.jobs_completed !== want.jobs_completed)
                    begin
                        $display("%0t: jobs_completed expected %0d actual %0d", $realtime,
                                 want.jobs_completed, rsp.jobs_completed);
                        errors++;
                    end
                    if (rsp.least_loaded !== want.least_loaded)
                    begin
                        $display("%0t: least_loaded expected %0d actual %0d", $realtime,
                                 want.least_loaded, rsp.least_loaded);
                        errors++;
                    end
                end
            end
            // Predict the result of each accepted item.
            if (req.valid && req.ready)
                expected_results.push_back(predict_dispatch(req.mode, req.queue_number,
                                                            req.job_tag, req.job_pages,
                                                            req.minutes));
            // Track register writes.
            if (psel && penable && pwrite && pready && paddr == CFG_ADDR)
                active_reg = pwdata[CFG_W-1:0];
        end
    end
endmodule

@@ test/least_loaded_multi_queue_dispatcher_tb.sv @@
// Stimulus and verdict for the least-loaded multi-queue dispatcher.
module least_loaded_multi_queue_dispatcher_tb;
    import lqd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]        REG_QUEUES_IN_USE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IGNORED      = 2'd3;
    localparam int                SETTLE_CYCLES     = 400;
    localparam int                ITEMS_PER_PHASE   = 320;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int          active_now;

    lqd_req_if req_ch ();
    lqd_rsp_if rsp_ch ();

    least_loaded_multi_queue_dispatcher i_dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lqd_scoreboard #(.CFG_ADDR(REG_QUEUES_IN_USE)) i_scoreboard (
        .clk(clk), .rst_n(rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Safety net against a hung block.
    initial
    begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                for (int c = 0; c < 300; c++)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one item and returns at the edge where it is taken.
    task automatic offer_item(logic [MODE_W-1:0] mode, logic [QNUM_W-1:0] qnum,
                              logic [TAG_IN_W-1:0] tag, logic [PAGES_W-1:0] pages,
                              logic [MIN_W-1:0] mins);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.queue_number <= qnum;
        req_ch.job_tag      <= tag;
        req_ch.job_pages    <= pages;
        req_ch.minutes      <= mins;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Waits for every result, lets the block settle, then writes the register.
    task automatic set_queues_in_use(logic [3:0] value);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_QUEUES_IN_USE;
        pwdata  <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_now = (value < 1) ? 1 : (value > 8) ? 8 : value;
    endtask

    // One random item; small tag pool and small sizes so duplicates and full queues occur.
    task automatic offer_random_item();
        int pick;
        logic [MODE_W-1:0]  mode;
        logic [QNUM_W-1:0]  qnum;
        logic [TAG_IN_W-1:0] tag;
        logic [PAGES_W-1:0] pages;
        logic [MIN_W-1:0]   mins;
        pick = $urandom_range(99);
        mode = (pick < 42) ? MODE_NAMED : (pick < 72) ? MODE_LEAST :
               (pick < 96) ? MODE_ADVANCE : MODE_IGNORED;
        qnum = ($urandom_range(99) < 85) ? $urandom_range(active_now, 1) : $urandom_range(15);
        tag  = ($urandom_range(99) < 70) ? $urandom_range(63) : $urandom;
        pick = $urandom_range(99);
        pages = (pick < 10) ? 16'd0 : (pick < 70) ? $urandom_range(20) : $urandom;
        pick = $urandom_range(99);
        mins = (pick < 10) ? 16'd0 : (pick < 55) ? $urandom_range(30) :
               (pick < 85) ? $urandom_range(200) : $urandom;
        offer_item(mode, qnum, tag, pages, mins);
    endtask

    initial
    begin
        logic [3:0] phase_setting [6] = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd3};
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= '0;
        req_ch.queue_number <= '0;
        req_ch.job_tag      <= '0;
        req_ch.job_pages    <= '0;
        req_ch.minutes      <= '0;
        hold_request  = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 83;
        active_now    = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the reset setting of one active queue.
        offer_item(MODE_ADVANCE, 4'd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_NAMED, 4'd1, 16'h0000, 16'h0000, 16'hFFFF);
        offer_item(MODE_NAMED, 4'd0, 16'h1234, 16'd5, 16'd0);
        offer_item(MODE_NAMED, 4'd2, 16'h1235, 16'd5, 16'd0);
        offer_item(MODE_NAMED, 4'd15, 16'h1236, 16'd5, 16'd0);
        offer_item(MODE_NAMED, 4'd1, 16'h0000, 16'd7, 16'd0);
        offer_item(MODE_LEAST, 4'd9, 16'hFFFF, 16'hFFFF, 16'd0);
        offer_item(MODE_IGNORED, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_item(MODE_ADVANCE, 4'd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_ADVANCE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Fill queue one past its depth, then flush it.
        for (int i = 0; i < 17; i++)
            offer_item(MODE_NAMED, 4'd1, 16'h0100 + i, 16'd1, 16'd0);
        offer_item(MODE_ADVANCE, 4'd0, 16'd0, 16'd0, 16'hFFFF);

        // Random phases across several register settings and idle patterns.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_queues_in_use(phase_setting[ph]);
            send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 83 : 0;
            recv_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 33 : 0;
            if (ph == 4)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_random_item();
        end
        req_ch.valid <= 1'b0;

        // Drain, then give a late result time to show up.
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
